FILE: sv/klsa_pkg.sv
// Package: shared constants and types for the keyed light slot allocator.
`timescale 1ns / 1ps
package klsa_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int WIDE_W = 9;

	localparam logic [1:0] CMD_NEW  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] HOW_KEY   = 2'd0;
	localparam logic [1:0] HOW_EXP   = 2'd1;
	localparam logic [1:0] HOW_FORCE = 2'd2;
	localparam logic [1:0] HOW_NONE  = 2'd3;

	// floor(p / 1000) == (p * RECIP) >> RECIP_SHIFT for every p below 2^28
	localparam int PROD_W = 28;
	localparam int RECIP_W = 29;
	localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
	localparam int RECIP_SHIFT = 38;
	localparam int QPROD_W = PROD_W + RECIP_W;
	localparam int LOSS_W = QPROD_W - RECIP_SHIFT;

	typedef struct packed {
		logic load;
		logic scan;
		logic alloc_wr;
		logic tick_issue;
		logic res_none;
		logic res_read;
		logic use_sel;
		logic [IDX_W-1:0] ptr;
	} ctl_t;

endpackage

FILE: sv/klsa_ctrl.sv
// Controller: sequences allocation walks, decay walks, reads and the result strobe.
`timescale 1ns / 1ps
module klsa_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] command,
	output logic busy,
	output logic done,
	output klsa_pkg::ctl_t ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_AWR   = 3'd2;
	localparam logic [2:0] S_TICK  = 3'd3;
	localparam logic [2:0] S_TD1   = 3'd4;
	localparam logic [2:0] S_TD2   = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;
	localparam logic [2:0] S_RESP  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [klsa_pkg::IDX_W-1:0] ptr_q;
	logic last;

	assign last = (ptr_q == klsa_pkg::IDX_W'(klsa_pkg::SLOT_COUNT - 1));

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.ptr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (command)
						klsa_pkg::CMD_NEW:  state_d = S_ALLOC;
						klsa_pkg::CMD_TICK: state_d = S_TICK;
						klsa_pkg::CMD_READ: state_d = S_READ;
						klsa_pkg::CMD_NONE: begin
							ctl.res_none = 1'b1;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_ALLOC: begin
				ctl.scan = 1'b1;
				if (last) state_d = S_AWR;
			end
			S_AWR: begin
				ctl.alloc_wr = 1'b1;
				state_d = S_RESP;
			end
			S_TICK: begin
				ctl.tick_issue = 1'b1;
				if (last) state_d = S_TD1;
			end
			S_TD1: state_d = S_TD2;
			S_TD2: begin
				ctl.res_none = 1'b1;
				state_d = S_RESP;
			end
			S_READ: begin
				ctl.use_sel = 1'b1;
				ctl.res_read = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ALLOC || state_q == S_TICK) begin
				ptr_q <= last ? '0 : ptr_q + 1'b1;
			end else begin
				ptr_q <= '0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

FILE: sv/klsa_dp.sv
// Datapath: slot table, allocation scan, decay pipeline and result registers.
`timescale 1ns / 1ps
module klsa_dp (
	input  logic clk,
	input  logic arst_n,
	input  klsa_pkg::ctl_t ctl,
	input  logic [15:0] light_key,
	input  logic [31:0] now_ms,
	input  logic [15:0] lifetime_ms,
	input  logic [17:0] start_radius,
	input  logic [17:0] decay_rate,
	input  logic [9:0] frame_ms,
	input  logic [4:0] slot_select,
	output logic [4:0] slot_index,
	output logic [1:0] how_chosen,
	output logic [17:0] radius_out,
	output logic [15:0] key_out,
	output logic live
);

	localparam int IW = klsa_pkg::IDX_W;
	localparam int WW = klsa_pkg::WIDE_W;

	logic [15:0] key_q [klsa_pkg::SLOT_COUNT];
	logic [31:0] exp_q [klsa_pkg::SLOT_COUNT];
	logic [17:0] rad_q [klsa_pkg::SLOT_COUNT];
	logic [17:0] dec_q [klsa_pkg::SLOT_COUNT];

	logic [15:0] lkey_q;
	logic [31:0] now_q;
	logic [15:0] life_q;
	logic [17:0] srad_q;
	logic [17:0] sdec_q;
	logic [9:0] frame_q;
	logic [4:0] sel_q;

	logic fkey_q, fexp_q;
	logic [IW-1:0] kidx_q, eidx_q;

	logic [WW-1:0] sel_w;
	logic in_range;
	logic [IW-1:0] rd_idx;
	logic [15:0] rd_key;
	logic [31:0] rd_exp;
	logic [17:0] rd_rad;
	logic [17:0] rd_dec;
	logic rd_expired;

	logic [IW-1:0] pick;
	logic [1:0] how;
	logic [WW-1:0] pick_w;

	logic valid_s1, zero_s1;
	logic [IW-1:0] idx_s1;
	logic [17:0] rad_s1;
	logic [klsa_pkg::PROD_W-1:0] prod_s1;
	logic valid_s2, zero_s2;
	logic [IW-1:0] idx_s2;
	logic [17:0] rad_s2;
	logic [klsa_pkg::QPROD_W-1:0] q_s2;
	logic [klsa_pkg::LOSS_W-1:0] loss;
	logic [17:0] new_rad;

	assign sel_w = WW'(sel_q);
	assign in_range = (sel_w < WW'(klsa_pkg::SLOT_COUNT));
	assign rd_idx = ctl.use_sel ? sel_w[IW-1:0] : ctl.ptr;
	assign rd_key = key_q[rd_idx];
	assign rd_exp = exp_q[rd_idx];
	assign rd_rad = rad_q[rd_idx];
	assign rd_dec = dec_q[rd_idx];
	assign rd_expired = (rd_exp < now_q);

	always_comb begin
		priority if (fkey_q) begin
			pick = kidx_q;
			how = klsa_pkg::HOW_KEY;
		end else if (fexp_q) begin
			pick = eidx_q;
			how = klsa_pkg::HOW_EXP;
		end else begin
			pick = '0;
			how = klsa_pkg::HOW_FORCE;
		end
	end
	assign pick_w = WW'(pick);

	assign loss = q_s2[klsa_pkg::QPROD_W-1:klsa_pkg::RECIP_SHIFT];
	assign new_rad = (zero_s2 || loss >= klsa_pkg::LOSS_W'(rad_s2)) ? '0
		: rad_s2 - loss[17:0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lkey_q <= light_key;
			now_q <= now_ms;
			life_q <= lifetime_ms;
			srad_q <= start_radius;
			sdec_q <= decay_rate;
			frame_q <= frame_ms;
			sel_q <= slot_select;
		end
		if (ctl.scan) begin
			if (!fkey_q && lkey_q != '0 && rd_key == lkey_q) kidx_q <= ctl.ptr;
			if (!fexp_q && rd_expired) eidx_q <= ctl.ptr;
		end
		idx_s1 <= ctl.ptr;
		rad_s1 <= rd_rad;
		zero_s1 <= rd_expired;
		prod_s1 <= klsa_pkg::PROD_W'(rd_dec * frame_q);
		idx_s2 <= idx_s1;
		rad_s2 <= rad_s1;
		zero_s2 <= zero_s1;
		q_s2 <= klsa_pkg::QPROD_W'(prod_s1) * klsa_pkg::QPROD_W'(klsa_pkg::RECIP);
		priority if (ctl.alloc_wr) begin
			slot_index <= pick_w[4:0];
			how_chosen <= how;
			radius_out <= srad_q;
			key_out <= lkey_q;
			live <= (srad_q != '0);
		end else if (ctl.res_read) begin
			slot_index <= sel_q;
			how_chosen <= klsa_pkg::HOW_NONE;
			radius_out <= in_range ? rd_rad : '0;
			key_out <= in_range ? rd_key : '0;
			live <= in_range && (rd_rad != '0);
		end else if (ctl.res_none) begin
			slot_index <= '0;
			how_chosen <= klsa_pkg::HOW_NONE;
			radius_out <= '0;
			key_out <= '0;
			live <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fkey_q <= 1'b0;
			fexp_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < klsa_pkg::SLOT_COUNT; i++) begin
				key_q[i] <= '0;
				exp_q[i] <= '0;
				rad_q[i] <= '0;
				dec_q[i] <= '0;
			end
		end else begin
			valid_s1 <= ctl.tick_issue;
			valid_s2 <= valid_s1;
			if (ctl.load) begin
				fkey_q <= 1'b0;
				fexp_q <= 1'b0;
			end else if (ctl.scan) begin
				if (lkey_q != '0 && rd_key == lkey_q) fkey_q <= 1'b1;
				if (rd_expired) fexp_q <= 1'b1;
			end
			priority if (ctl.alloc_wr) begin
				key_q[pick] <= lkey_q;
				exp_q[pick] <= now_q + 32'(life_q);
				rad_q[pick] <= srad_q;
				dec_q[pick] <= sdec_q;
			end else if (valid_s2) begin
				rad_q[idx_s2] <= new_rad;
			end
		end
	end

endmodule

FILE: sv/keyed_light_slot_allocator.sv
// Top level: keyed light slot allocator, controller plus datapath.
//
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------------
// command  | start / busy       | command, light_key, now_ms, lifetime_ms,
//          |                    | start_radius, decay_rate, frame_ms, slot_select
// result   | done (one cycle)   | slot_index, how_chosen, radius_out, key_out, live
//
// A transaction is taken when start is high and busy is low.
// New light: a one-slot-per-cycle scan, then a write, then done.
// Tick: one slot per cycle through a 2-stage decay pipeline, then done.
// Read: a lookup, then done; an unused command goes straight to done. Busy falls the cycle after done.
// Reset clears the slot table at once. The receiver cannot stall results.
`timescale 1ns / 1ps
module keyed_light_slot_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic [15:0] light_key,
	input  logic [31:0] now_ms,
	input  logic [15:0] lifetime_ms,
	input  logic [17:0] start_radius,
	input  logic [17:0] decay_rate,
	input  logic [9:0] frame_ms,
	input  logic [4:0] slot_select,
	output logic done,
	output logic [4:0] slot_index,
	output logic [1:0] how_chosen,
	output logic [17:0] radius_out,
	output logic [15:0] key_out,
	output logic live
);

	klsa_pkg::ctl_t ctl;

	klsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.busy(busy),
		.done(done),
		.ctl(ctl)
	);

	klsa_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.light_key(light_key),
		.now_ms(now_ms),
		.lifetime_ms(lifetime_ms),
		.start_radius(start_radius),
		.decay_rate(decay_rate),
		.frame_ms(frame_ms),
		.slot_select(slot_select),
		.slot_index(slot_index),
		.how_chosen(how_chosen),
		.radius_out(radius_out),
		.key_out(key_out),
		.live(live)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (live == (radius_out != '0))) else $error("live disagrees with radius");

endmodule

FILE: tb/keyed_light_slot_allocator_tb.sv
// Testbench: directed and random light-slot commands checked against a slot-table predictor.
`timescale 1ns / 1ps
module keyed_light_slot_allocator_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0] command;
		logic [15:0] light_key;
		logic [31:0] now_ms;
		logic [15:0] lifetime_ms;
		logic [17:0] start_radius;
		logic [17:0] decay_rate;
		logic [9:0] frame_ms;
		logic [4:0] slot_select;
	} light_cmd_t;

	typedef struct packed {
		logic [4:0] slot_index;
		logic [1:0] how_chosen;
		logic [17:0] radius_out;
		logic [15:0] key_out;
		logic live;
	} light_res_t;

	class light_table_scoreboard;
		logic [15:0] key_tbl [klsa_pkg::SLOT_COUNT];
		logic [31:0] expiry_tbl [klsa_pkg::SLOT_COUNT];
		logic [17:0] radius_tbl [klsa_pkg::SLOT_COUNT];
		logic [17:0] decay_tbl [klsa_pkg::SLOT_COUNT];
		light_res_t awaited [$];
		int fail_count;

		function new();
			for (int i = 0; i < klsa_pkg::SLOT_COUNT; i++) begin
				key_tbl[i] = '0;
				expiry_tbl[i] = '0;
				radius_tbl[i] = '0;
				decay_tbl[i] = '0;
			end
			fail_count = 0;
		endfunction

		// Update the slot table for one accepted transaction and queue its result.
		function void note_command(light_cmd_t c);
			light_res_t r;
			int pick;
			logic [1:0] how;
			logic found;
			logic [63:0] loss;
			r = '0;
			r.how_chosen = klsa_pkg::HOW_NONE;
			case (c.command)
				klsa_pkg::CMD_NEW: begin
					pick = 0;
					how = klsa_pkg::HOW_FORCE;
					found = 1'b0;
					if (c.light_key != 16'd0) begin
						for (int i = 0; i < klsa_pkg::SLOT_COUNT; i++) begin
							if (!found && key_tbl[i] == c.light_key) begin
								pick = i;
								how = klsa_pkg::HOW_KEY;
								found = 1'b1;
							end
						end
					end
					for (int i = 0; i < klsa_pkg::SLOT_COUNT; i++) begin
						if (!found && expiry_tbl[i] < c.now_ms) begin
							pick = i;
							how = klsa_pkg::HOW_EXP;
							found = 1'b1;
						end
					end
					key_tbl[pick] = c.light_key;
					radius_tbl[pick] = c.start_radius;
					decay_tbl[pick] = c.decay_rate;
					expiry_tbl[pick] = c.now_ms + 32'(c.lifetime_ms);
					r.slot_index = pick[4:0];
					r.how_chosen = how;
					r.radius_out = c.start_radius;
					r.key_out = c.light_key;
				end
				klsa_pkg::CMD_TICK: begin
					for (int i = 0; i < klsa_pkg::SLOT_COUNT; i++) begin
						if (radius_tbl[i] != 18'd0) begin
							if (expiry_tbl[i] < c.now_ms) begin
								radius_tbl[i] = 18'd0;
							end else begin
								loss = (64'(decay_tbl[i]) * 64'(c.frame_ms)) / 64'd1000;
								if (loss >= 64'(radius_tbl[i]))
									radius_tbl[i] = 18'd0;
								else
									radius_tbl[i] = radius_tbl[i] - loss[17:0];
							end
						end
					end
				end
				klsa_pkg::CMD_READ: begin
					r.slot_index = c.slot_select;
					if (c.slot_select < klsa_pkg::SLOT_COUNT) begin
						r.radius_out = radius_tbl[c.slot_select];
						r.key_out = key_tbl[c.slot_select];
					end
				end
				default: ;
			endcase
			r.live = (r.radius_out != 18'd0);
			awaited.push_back(r);
		endfunction

		function void check_result(light_res_t got);
			light_res_t want;
			if (awaited.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result with nothing outstanding: idx %0d how %0d rad %h key %h",
						$time, got.slot_index, got.how_chosen, got.radius_out, got.key_out,
						" live %b", got.live);
				return;
			end
			want = awaited.pop_front();
			if (got.slot_index !== want.slot_index || got.how_chosen !== want.how_chosen ||
					got.radius_out !== want.radius_out || got.key_out !== want.key_out ||
					got.live !== want.live) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: mismatch exp idx %0d how %0d rad %h key %h live %b",
						$time, want.slot_index, want.how_chosen, want.radius_out, want.key_out,
						want.live);
					$display("%0t:          got idx %0d how %0d rad %h key %h live %b",
						$time, got.slot_index, got.how_chosen, got.radius_out, got.key_out,
						got.live);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic [15:0] light_key;
	logic [31:0] now_ms;
	logic [15:0] lifetime_ms;
	logic [17:0] start_radius;
	logic [17:0] decay_rate;
	logic [9:0] frame_ms;
	logic [4:0] slot_select;
	logic done;
	logic [4:0] slot_index;
	logic [1:0] how_chosen;
	logic [17:0] radius_out;
	logic [15:0] key_out;
	logic live;

	light_table_scoreboard sb;
	logic [31:0] sim_now = 32'd0;
	int unsigned cycle_count = 0;

	keyed_light_slot_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.light_key(light_key),
		.now_ms(now_ms),
		.lifetime_ms(lifetime_ms),
		.start_radius(start_radius),
		.decay_rate(decay_rate),
		.frame_ms(frame_ms),
		.slot_select(slot_select),
		.done(done),
		.slot_index(slot_index),
		.how_chosen(how_chosen),
		.radius_out(radius_out),
		.key_out(key_out),
		.live(live)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyed_light_slot_allocator_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({slot_index, how_chosen, radius_out, key_out, live});
	end

	function automatic light_cmd_t mk(logic [1:0] cmd, logic [15:0] key, logic [31:0] now,
			logic [15:0] life, logic [17:0] rad, logic [17:0] dec, logic [9:0] frame,
			logic [4:0] sel);
		light_cmd_t c;
		c.command = cmd;
		c.light_key = key;
		c.now_ms = now;
		c.lifetime_ms = life;
		c.start_radius = rad;
		c.decay_rate = dec;
		c.frame_ms = frame;
		c.slot_select = sel;
		return c;
	endfunction

	// Mostly a coherent timeline with a small key pool; some noise on time and fields.
	function automatic light_cmd_t random_command();
		light_cmd_t c;
		int unsigned roll;
		roll = $urandom_range(99);
		c.command = (roll < 45) ? klsa_pkg::CMD_NEW : (roll < 75) ? klsa_pkg::CMD_TICK :
			(roll < 95) ? klsa_pkg::CMD_READ : klsa_pkg::CMD_NONE;
		if ($urandom_range(49) == 0)
			sim_now = $urandom;
		else
			sim_now = sim_now + 32'($urandom_range(0, 150));
		c.now_ms = ($urandom_range(99) < 8) ? 32'($urandom) : sim_now;
		roll = $urandom_range(99);
		c.light_key = (roll < 15) ? 16'd0 : (roll < 85) ? 16'($urandom_range(1, 12)) :
			16'($urandom);
		c.lifetime_ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		c.start_radius = 18'($urandom);
		c.decay_rate = ($urandom_range(4) == 0) ? 18'($urandom) : 18'($urandom_range(0, 4000));
		c.frame_ms = ($urandom_range(99) < 15) ? 10'($urandom_range(0, 1023)) :
			10'($urandom_range(0, 100));
		c.slot_select = 5'($urandom_range(0, 31));
		return c;
	endfunction

	task automatic send_command(light_cmd_t c);
		start <= 1'b1;
		command <= c.command;
		light_key <= c.light_key;
		now_ms <= c.now_ms;
		lifetime_ms <= c.lifetime_ms;
		start_radius <= c.start_radius;
		decay_rate <= c.decay_rate;
		frame_ms <= c.frame_ms;
		slot_select <= c.slot_select;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_quiet();
		if (sb.awaited.size() != 0) begin
			start <= 1'b0;
			while (sb.awaited.size() != 0) @(posedge clk);
		end
	endtask

	task automatic run_directed();
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd31));
		// nothing expired at time zero: forced onto slot 0
		send_command(mk(klsa_pkg::CMD_NEW, 16'd0, 32'd0, 16'd0, 18'h3FFFF, 18'd0, 10'd0,
			5'd0));
		send_command(mk(klsa_pkg::CMD_TICK, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd1000,
			5'd0));
		send_command(mk(klsa_pkg::CMD_NEW, 16'hFFFF, 32'd5, 16'hFFFF, 18'd1, 18'h3FFFF,
			10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_NEW, 16'hFFFF, 32'd5, 16'hFFFF, 18'd1, 18'h3FFFF,
			10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_NEW, 16'h1234, 32'd5, 16'd100, 18'h3FFFF, 18'h3FFFF,
			10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_NEW, 16'd5, 32'd1000, 16'd60000, 18'd1000, 18'd256,
			10'd0, 5'd0));
		// frame time above 1000, no clamp
		send_command(mk(klsa_pkg::CMD_TICK, 16'd0, 32'd10, 16'd0, 18'd0, 18'd0, 10'd1023,
			5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd1));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd2));
		send_command(mk(klsa_pkg::CMD_NEW, 16'd5, 32'd1000, 16'd60000, 18'd1000, 18'd256,
			10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_TICK, 16'd0, 32'd1000, 16'd0, 18'd0, 18'd0, 10'd500,
			5'd0));
		send_command(mk(klsa_pkg::CMD_TICK, 16'd0, 32'd1000, 16'd0, 18'd0, 18'd0, 10'd0,
			5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd2));
		send_command(mk(klsa_pkg::CMD_NONE, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 18'h3FFFF,
			18'h3FFFF, 10'h3FF, 5'd31));
		// expiry wraps past 2^32
		send_command(mk(klsa_pkg::CMD_NEW, 16'd0, 32'hFFFFFFFF, 16'hFFFF, 18'd100, 18'd256,
			10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_TICK, 16'd0, 32'hFFFFFFFF, 16'd0, 18'd0, 18'd0, 10'd1,
			5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd0));
		send_command(mk(klsa_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 18'd0, 18'd0, 10'd0, 5'd2));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		command = klsa_pkg::CMD_NONE;
		light_key = '0;
		now_ms = '0;
		lifetime_ms = '0;
		start_radius = '0;
		decay_rate = '0;
		frame_ms = '0;
		slot_select = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_quiet();
		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				if ($urandom_range(99) < ((ph == 0) ? 15 : (ph == 1) ? 66 : 0))
					idle_cycles($urandom_range(1, 45));
				send_command(random_command());
			end
			wait_quiet();
		end
		start <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.fail_count += sb.awaited.size();
		if (sb.fail_count == 0)
			$display("keyed_light_slot_allocator_tb passed");
		else
			$display("keyed_light_slot_allocator_tb failed");
		$finish;
	end

endmodule
